// ===== rtl/sitc_pkg.sv =====
// Shared constants and types for the spiral index to coordinate block.
// Used by the root cells, the placement stage and the top level.
// Depends on nothing.
package sitc_pkg;

   // Fixed field widths.
   localparam int POS_W   = 32;
   localparam int COORD_W = 16;

   // Root of a 32-bit value, its remainder and the offset into a ring.
   localparam int ROOT_W = POS_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int L_W    = 20;

   // Default width of the grid side.
   localparam int SIDE_BITS_DEFAULT = 16;

   // Data that travels along the chain of root cells.
   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [POS_W-1:0]  radicand;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sitc_cell_type;

endpackage

// ===== rtl/sitc_root_cell.sv =====
// One cell of the square root chain: resolves one root bit per transfer.
// Depends on sitc_pkg.
// Cells hand their data to the next cell and stall from the next cell back.
module sitc_root_cell #(
   parameter int DIGIT     = 0,
   parameter int SIDE_BITS = sitc_pkg::SIDE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  sitc_pkg::sitc_cell_type in_data,
   input  logic [SIDE_BITS-1:0]    in_side,
   output logic                    in_hold,
   output logic                    out_valid,
   output sitc_pkg::sitc_cell_type out_data,
   output logic [SIDE_BITS-1:0]    out_side,
   input  logic                    out_hold
);
   import sitc_pkg::*;

   logic                 valid_ff;
   sitc_cell_type        data_ff;
   sitc_cell_type        data_in;
   logic [SIDE_BITS-1:0] side_ff;
   logic                 load;
   logic [REM_W-1:0]     rem_shift;
   logic [REM_W-1:0]     trial;

   // The cell takes new data unless it is full and the next cell holds.
   assign in_hold = valid_ff && out_hold;
   assign load    = !in_hold;

   // Restoring root step on the next two radicand bits.
   always_comb begin
      rem_shift = REM_W'({in_data.rem[REM_W-4:0], in_data.radicand[2*DIGIT +: 2]});
      trial     = REM_W'({in_data.root, 2'b01});
      data_in   = in_data;
      if (rem_shift >= trial) begin
         data_in.rem  = rem_shift - trial;
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_shift;
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
      end
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/sitc_place.sv =====
// Placement stages: ring size, range check and side selection, then the
// output register. Depends on sitc_pkg.
module sitc_place #(
   parameter int SIDE_BITS = sitc_pkg::SIDE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  sitc_pkg::sitc_cell_type        in_data,
   input  logic [SIDE_BITS-1:0]           in_side,
   output logic                           in_hold,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sitc_pkg::COORD_W-1:0]   rsp_line_number,
   output logic [sitc_pkg::COORD_W-1:0]   rsp_column_number,
   output logic                           rsp_outside_grid
);
   import sitc_pkg::*;

   localparam int SQ_W  = 2 * SIDE_BITS;
   localparam int CMP_W = (SQ_W > POS_W) ? SQ_W : POS_W;

   // Ring stage registers.
   logic                a_valid_ff;
   logic [POS_W-1:0]    a_pos_ff;
   logic [SQ_W-1:0]     a_side_sq_ff;
   logic [POS_W-1:0]    a_ring_ff;
   logic [ROOT_W-1:0]   a_p_ff;
   logic [COORD_W-1:0]  a_centre_ff;
   logic                a_hold;

   // Output registers.
   logic                b_valid_ff;
   logic [COORD_W-1:0]  b_line_ff;
   logic [COORD_W-1:0]  b_column_ff;
   logic                b_outside_ff;
   logic                b_hold;

   logic [ROOT_W:0]     root_inc;
   logic [ROOT_W-1:0]   p_in;
   logic [ROOT_W:0]     odd_full;
   logic [ROOT_W-1:0]   odd;
   logic [SIDE_BITS:0]  side_inc;

   logic [L_W-1:0]      l_val;
   logic [L_W-1:0]      two_p;
   logic [L_W-1:0]      four_p;
   logic [L_W-1:0]      six_p;
   logic [COORD_W-1:0]  cp;
   logic [COORD_W-1:0]  c_minus_p;
   logic [COORD_W-1:0]  c_plus_p;
   logic [COORD_W-1:0]  d;
   logic [COORD_W-1:0]  b_line_in;
   logic [COORD_W-1:0]  b_column_in;
   logic                b_outside_in;

   assign b_hold  = b_valid_ff && rsp_stall;
   assign a_hold  = a_valid_ff && b_hold;
   assign in_hold = a_hold;

   // Ring index p and the odd side 2p-1 of the inner square.
   always_comb begin
      root_inc = (ROOT_W+1)'(in_data.root) + 1'b1;
      p_in     = root_inc[ROOT_W:1];
      odd_full = {p_in, 1'b0} - 1'b1;
      odd      = (p_in == '0) ? ROOT_W'(1) : odd_full[ROOT_W-1:0];
      side_inc = (SIDE_BITS+1)'(in_side) + 1'b1;
   end

   // Ring stage: the two squares and the grid centre.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!a_hold) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!a_hold && in_valid) begin
         a_pos_ff     <= in_data.pos;
         a_side_sq_ff <= SQ_W'(in_side) * SQ_W'(in_side);
         a_ring_ff    <= POS_W'(odd) * POS_W'(odd);
         a_p_ff       <= p_in;
         a_centre_ff  <= COORD_W'(side_inc[SIDE_BITS:1]);
      end
   end

   // Side selection; coordinates wrap to the field width.
   always_comb begin
      l_val        = a_pos_ff[L_W-1:0] - a_ring_ff[L_W-1:0];
      two_p        = L_W'(a_p_ff) << 1;
      four_p       = L_W'(a_p_ff) << 2;
      six_p        = two_p + four_p;
      cp           = COORD_W'(a_p_ff);
      c_plus_p     = a_centre_ff + cp;
      c_minus_p    = a_centre_ff - cp;
      b_outside_in = CMP_W'(a_pos_ff) > CMP_W'(a_side_sq_ff);
      if (l_val <= two_p) begin
         d           = COORD_W'(l_val);
         b_line_in   = c_plus_p;
         b_column_in = c_plus_p - d;
      end else if (l_val <= four_p) begin
         d           = COORD_W'(l_val - two_p);
         b_line_in   = c_plus_p - d;
         b_column_in = c_minus_p;
      end else if (l_val <= six_p) begin
         d           = COORD_W'(l_val - four_p);
         b_line_in   = c_minus_p;
         b_column_in = c_minus_p + d;
      end else begin
         d           = COORD_W'(l_val - six_p);
         b_line_in   = c_minus_p + d;
         b_column_in = c_plus_p;
      end
      if (b_outside_in) begin
         b_line_in   = '0;
         b_column_in = '0;
      end
   end

   // Output register; holds its transfer while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!b_hold) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!b_hold && a_valid_ff) begin
         b_line_ff    <= b_line_in;
         b_column_ff  <= b_column_in;
         b_outside_ff <= b_outside_in;
      end
   end

   assign rsp_valid         = b_valid_ff;
   assign rsp_line_number   = b_line_ff;
   assign rsp_column_number = b_column_ff;
   assign rsp_outside_grid  = b_outside_ff;

endmodule

// ===== rtl/spiral_index_to_coordinate.sv =====
// Top level of the spiral index to coordinate block.
// Depends on sitc_pkg, sitc_root_cell and sitc_place.
//
// Usage: a request carries the grid side and a 1-based position on a square
// spiral that starts at the grid centre; the response gives line and column
// of that cell, or raises rsp_outside_grid (with zero coordinates) when the
// position lies beyond side squared. Position 0 is taken as the centre.
// Both channels transfer when valid is high and stall is low.
// Path: a request passes through 16 root cells, one bit of the root each,
// then the ring stage and the output register, which drives rsp_valid.
// Unstalled throughput: one transfer per cycle; every stage holds one item.
// When the receiver stalls, the response holds steady and the chain fills
// behind it; empty stages keep taking items, and req_stall rises only when
// every stage is full. Reset empties all stages; no other state exists.
module spiral_index_to_coordinate #(
   parameter int SIDE_BITS = sitc_pkg::SIDE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [SIDE_BITS-1:0]         req_grid_side,
   input  logic [sitc_pkg::POS_W-1:0]   req_spiral_position,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sitc_pkg::COORD_W-1:0] rsp_line_number,
   output logic [sitc_pkg::COORD_W-1:0] rsp_column_number,
   output logic                         rsp_outside_grid
);
   import sitc_pkg::*;

   sitc_cell_type        entry_data;
   sitc_cell_type        chain_data  [0:ROOT_W];
   logic                 chain_valid [0:ROOT_W];
   logic                 chain_hold  [0:ROOT_W];
   logic [SIDE_BITS-1:0] chain_side  [0:ROOT_W];

   // Entry: position zero counts as the centre; the root is taken of pos-1.
   always_comb begin
      entry_data.rem  = '0;
      entry_data.root = '0;
      if (req_spiral_position == '0) begin
         entry_data.pos      = POS_W'(1);
         entry_data.radicand = '0;
      end else begin
         entry_data.pos      = req_spiral_position;
         entry_data.radicand = req_spiral_position - 1'b1;
      end
   end

   assign chain_data[0]  = entry_data;
   assign chain_valid[0] = req_valid;
   assign chain_side[0]  = req_grid_side;
   assign req_stall      = chain_hold[0];

   // Chain of root cells, most significant root bit first.
   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      sitc_root_cell #(
         .DIGIT     (ROOT_W - 1 - i),
         .SIDE_BITS (SIDE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .in_side   (chain_side[i]),
         .in_hold   (chain_hold[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1]),
         .out_side  (chain_side[i+1]),
         .out_hold  (chain_hold[i+1])
      );
   end

   // Ring, range check and output register.
   sitc_place #(
      .SIDE_BITS (SIDE_BITS)
   ) u_place (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (chain_valid[ROOT_W]),
      .in_data           (chain_data[ROOT_W]),
      .in_side           (chain_side[ROOT_W]),
      .in_hold           (chain_hold[ROOT_W]),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .rsp_outside_grid  (rsp_outside_grid)
   );

endmodule

// ===== rtl/sitc_checker.sv =====
// Port-level checks for the spiral index to coordinate block, and the bind
// that attaches them to the top level. Depends on sitc_pkg.
module sitc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sitc_pkg::COORD_W-1:0] rsp_line_number,
   input logic [sitc_pkg::COORD_W-1:0] rsp_column_number,
   input logic                         rsp_outside_grid
);
   import sitc_pkg::*;

   // A position beyond the grid carries zero coordinates.
   a_outside_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside_grid |-> rsp_line_number == '0 &&
      rsp_column_number == '0)
      else $error("outside_grid response with non-zero coordinates");

   // The request side stalls only when the response side is blocked.
   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while the response side is free");

   // No response directly after reset.
   a_reset_empty : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // A stalled response stays and does not change.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_number) &&
      $stable(rsp_column_number) && $stable(rsp_outside_grid))
      else $error("stalled response changed");

endmodule

bind spiral_index_to_coordinate sitc_checker u_sitc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_line_number   (rsp_line_number),
   .rsp_column_number (rsp_column_number),
   .rsp_outside_grid  (rsp_outside_grid)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for spiral_index_to_coordinate: directed and random spiral queries.
// Results are checked against a predictor in this file; depends on sitc_pkg and the RTL.
module tb;

   import sitc_pkg::*;

   localparam int SIDE_W      = SIDE_BITS_DEFAULT;
   localparam int HOLD_CYCLES = 120;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 40;
   localparam int MAX_REPORTS = 10;

   // Random query shapes.
   typedef enum int {
      QUERY_MIXED,
      QUERY_RING
   } query_kind_type;

   // One query together with the coordinate that it should produce.
   typedef struct {
      logic [SIDE_W-1:0]  side;
      logic [POS_W-1:0]   position;
      logic [COORD_W-1:0] line_no;
      logic [COORD_W-1:0] column_no;
      logic               outside;
   } spiral_query_type;

   logic               clock               = 1'b0;
   logic               reset               = 1'b1;
   logic               req_valid           = 1'b0;
   logic               req_stall;
   logic [SIDE_W-1:0]  req_grid_side       = '0;
   logic [POS_W-1:0]   req_spiral_position = '0;
   logic               rsp_valid;
   logic               rsp_stall           = 1'b0;
   logic [COORD_W-1:0] rsp_line_number;
   logic [COORD_W-1:0] rsp_column_number;
   logic               rsp_outside_grid;

   spiral_query_type pending_coords[$];
   int               error_count       = 0;
   int               idle_cycles       = 0;
   bit               sender_idles      = 1'b0;
   bit               receiver_idles    = 1'b0;
   bit               long_hold_request = 1'b0;

   spiral_index_to_coordinate i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_grid_side      (req_grid_side),
      .req_spiral_position(req_spiral_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_number    (rsp_line_number),
      .rsp_column_number  (rsp_column_number),
      .rsp_outside_grid   (rsp_outside_grid)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Exact floor of the square root, digit by digit.
   function automatic longint unsigned floor_sqrt(input longint unsigned value);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned probe;
      rem   = value;
      root  = 0;
      probe = 64'h1 << 62;
      while (probe > rem)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Line and column of a spiral position, or the outside flag.
   function automatic spiral_query_type place_on_spiral(input logic [SIDE_W-1:0] side,
                                                        input logic [POS_W-1:0] position);
      longint unsigned  pos;
      longint unsigned  side_u;
      longint unsigned  ring;
      longint unsigned  p;
      longint unsigned  l;
      longint           sp;
      longint           sc;
      longint           sl;
      longint           line_v;
      longint           col_v;
      spiral_query_type r;
      r.side     = side;
      r.position = position;
      pos        = 64'(position);
      side_u     = 64'(side);
      if (pos == 0)
         pos = 1;
      if (pos > side_u * side_u) begin
         r.line_no   = '0;
         r.column_no = '0;
         r.outside   = 1'b1;
         return r;
      end
      p    = (floor_sqrt(pos - 1) + 1) >> 1;
      ring = (p == 0) ? 1 : (2 * p - 1) * (2 * p - 1);
      l    = pos - ring;
      sp   = longint'(p);
      sc   = longint'((side_u + 1) >> 1);
      sl   = longint'(l);
      // The ring offset picks one of the four sides, each 2p cells long.
      if (l <= 2 * p) begin
         line_v = sc + sp;
         col_v  = sc + sp - sl;
      end else if (l <= 4 * p) begin
         sl     = sl - 2 * sp;
         line_v = sc + sp - sl;
         col_v  = sc - sp;
      end else if (l <= 6 * p) begin
         sl     = sl - 4 * sp;
         line_v = sc - sp;
         col_v  = sc - sp + sl;
      end else begin
         sl     = sl - 6 * sp;
         line_v = sc - sp + sl;
         col_v  = sc + sp;
      end
      r.line_no   = line_v[COORD_W-1:0];
      r.column_no = col_v[COORD_W-1:0];
      r.outside   = 1'b0;
      return r;
   endfunction

   // Offers one query, waits for its transfer and records what it should give.
   task automatic send_query(input logic [SIDE_W-1:0] side, input logic [POS_W-1:0] position);
      int gap;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_grid_side       <= side;
      req_spiral_position <= position;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_coords.push_back(place_on_spiral(side, position));
   endtask

   // Draws one random query; most land inside the grid on a chosen ring.
   task automatic send_random_query(input query_kind_type kind);
      logic [SIDE_W-1:0] side;
      logic [POS_W-1:0]  pos;
      longint unsigned   sq;
      longint unsigned   p;
      longint unsigned   l;
      int                sel;
      sel = (kind == QUERY_RING) ? 0 : $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0)
         side = SIDE_W'($urandom_range(1, 31));
      else
         side = SIDE_W'($urandom_range(1, 16'hFFFF));
      side[0] = 1'b1;
      sq      = longint'(side) * longint'(side);
      if (sel < 50) begin
         // A ring and an offset into it, with corners drawn often.
         if (side < 3) begin
            pos = 1;
         end else begin
            p = 64'($urandom_range(1, (side - 1) / 2));
            if ($urandom_range(0, 2) == 0) begin
               l = 2 * p * $urandom_range(1, 4) + $urandom_range(0, 1);
               if (l > 8 * p)
                  l = 8 * p;
            end else begin
               l = 64'($urandom_range(1, POS_W'(8 * p)));
            end
            pos = POS_W'((2 * p - 1) * (2 * p - 1) + l);
         end
      end else if (sel < 75) begin
         pos = $urandom_range(1, POS_W'(sq));
      end else if (sel < 85) begin
         // Around the last cell of the grid.
         pos = POS_W'(sq - 1 + $urandom_range(0, 2));
      end else if (sel < 92) begin
         side = SIDE_W'($urandom());
         pos  = $urandom();
      end else begin
         // Zero or even sides and zero positions.
         side    = ($urandom_range(0, 3) == 0) ? '0 : SIDE_W'($urandom_range(0, 16'hFFFF));
         side[0] = 1'b0;
         sq      = longint'(side) * longint'(side);
         pos     = ($urandom_range(0, 1) == 0) ? '0 : POS_W'($urandom_range(0, POS_W'(sq)));
      end
      send_query(side, pos);
   endtask

   // Receiver: random stall bursts, or one long hold when asked.
   initial begin : stall_driver
      int burst;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall         <= 1'b0;
            long_hold_request  = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each result transfer is compared with the oldest outstanding query.
   always @(posedge clock) begin
      spiral_query_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_coords.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result: line %0d column %0d outside %0b",
                        rsp_line_number, rsp_column_number, rsp_outside_grid);
         end else begin
            want = pending_coords.pop_front();
            if (rsp_line_number !== want.line_no || rsp_column_number !== want.column_no ||
                rsp_outside_grid !== want.outside) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch side %0d pos %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                           want.side, want.position, want.line_no, want.column_no,
                           want.outside, rsp_line_number, rsp_column_number,
                           rsp_outside_grid);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("spiral_index_to_coordinate test failed");
         $finish;
      end
   end

   // Grid extremes, every side of a ring, zero and even cases.
   task automatic test_directed_cases();
      send_query(16'd1, 32'd1);
      send_query(16'd1, 32'd2);
      send_query(16'd1, 32'd0);
      send_query(16'd0, 32'd0);
      send_query(16'd0, 32'd1);
      for (int i = 2; i <= 9; i++)
         send_query(16'd5, i);
      send_query(16'd5, 32'd10);
      send_query(16'd5, 32'd25);
      send_query(16'd5, 32'd26);
      send_query(16'd2, 32'd3);
      send_query(16'd2, 32'd4);
      send_query(16'd4, 32'd16);
      send_query(16'hFFFF, 32'd1);
      send_query(16'hFFFF, 32'd4294836225);
      send_query(16'hFFFF, 32'd4294836226);
      send_query(16'hFFFF, 32'hFFFF_FFFF);
      send_query(16'hFFFE, 32'd4294705156);
   endtask

   // Positions spread over the rings and their four sides.
   task automatic test_ring_sides();
      repeat (150) send_random_query(QUERY_RING);
   endtask

   // A long receiver hold while queries keep coming, so the chain fills.
   task automatic test_backpressure();
      sender_idles      = 1'b0;
      long_hold_request = 1'b1;
      repeat (80) send_random_query(QUERY_MIXED);
   endtask

   // General random queries with idling on both channels.
   task automatic test_random_queries();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (220) send_random_query(QUERY_MIXED);
   endtask

   // Closing stream with no idling at all.
   task automatic test_full_rate_stream();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      repeat (100) send_random_query(QUERY_MIXED);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      test_ring_sides();
      test_backpressure();
      test_random_queries();
      test_full_rate_stream();
      req_valid <= 1'b0;
      while (pending_coords.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("spiral_index_to_coordinate test passed");
      else
         $display("spiral_index_to_coordinate test failed");
      $finish;
   end

endmodule
